>>> hdl/mrfd_pkg.sv
// Package with the shared types and constants of the motor reply frame decoder.
`default_nettype none

package mrfd_pkg;

    localparam logic [7:0] TERMINATOR_BYTE  = 8'h6B;
    localparam logic [7:0] FN_POSITION      = 8'h30;
    localparam logic [7:0] FN_FAILED        = 8'h00;
    localparam logic [7:0] FN_TORQUE_BACK   = 8'hF5;
    localparam logic [3:0] POSITION_LEN     = 4'd8;
    localparam logic [3:0] LEN_MAX          = 4'd15;
    localparam int         STORE_DEPTH      = 7;
    localparam logic [7:0] HIGHEST_JOINT_RST = 8'd5;

    localparam logic [2:0] ST_POS_OK        = 3'd0;
    localparam logic [2:0] ST_JOINT_RANGE   = 3'd1;
    localparam logic [2:0] ST_FAILED        = 3'd2;
    localparam logic [2:0] ST_TORQUE_BACK   = 3'd3;
    localparam logic [2:0] ST_OTHER         = 3'd4;

    typedef struct packed {
        logic        close;
        logic [3:0]  len;
        logic [7:0]  joint;
        logic [7:0]  fn;
        logic [31:0] pos;
    } frame_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  joint;
        logic [31:0] pos;
        logic [3:0]  len;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/mrfd_frame_store.sv
// Frame byte counter and store of the first seven bytes of the open frame.
`default_nettype none

module mrfd_frame_store
    import mrfd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic [7:0] rx_byte,
    output frame_t          frame
);

    logic [3:0] byte_count_reg;
    logic [3:0] byte_count_next;
    logic [7:0] frame_bytes_reg [STORE_DEPTH];
    logic       drop;
    logic       store_en;
    logic [3:0] len_inc;

    assign drop     = (rx_byte == 8'h00) && (byte_count_reg == 4'd0);
    assign store_en = advance && !drop && (byte_count_reg < 4'(STORE_DEPTH));
    assign len_inc  = (byte_count_reg < LEN_MAX) ? byte_count_reg + 4'd1 : LEN_MAX;

    always_comb begin
        frame.close = advance && !drop && (rx_byte == TERMINATOR_BYTE);
        frame.len   = len_inc;
        frame.joint = (byte_count_reg == 4'd0) ? rx_byte : frame_bytes_reg[0];
        frame.fn    = (byte_count_reg == 4'd1) ? rx_byte : frame_bytes_reg[1];
        frame.pos   = {frame_bytes_reg[3], frame_bytes_reg[4],
                       frame_bytes_reg[5], frame_bytes_reg[6]};
    end

    always_comb begin
        byte_count_next = byte_count_reg;
        if (advance && !drop) begin
            if (rx_byte == TERMINATOR_BYTE) begin
                byte_count_next = 4'd0;
            end else begin
                byte_count_next = len_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 4'd0;
        end else begin
            byte_count_reg <= byte_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            frame_bytes_reg[byte_count_reg[2:0]] <= rx_byte;
        end
    end

    // A closed frame always leaves the counter at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame.close |=> byte_count_reg == 4'd0)
        else $error("Byte count not cleared after frame close.");

endmodule

`default_nettype wire

>>> hdl/mrfd_classify.sv
// Classification of a closed frame into the result status and position.
`default_nettype none

module mrfd_classify
    import mrfd_pkg::*;
(
    input  wire frame_t      frame,
    input  wire logic [7:0]  highest_joint,
    output result_t          result
);

    logic is_position;
    logic joint_ok;

    assign is_position = (frame.fn == FN_POSITION) && (frame.len == POSITION_LEN);
    assign joint_ok    = (frame.joint != 8'd0) && (frame.joint <= highest_joint);

    always_comb begin
        result.status = ST_OTHER;
        result.joint  = frame.joint;
        result.pos    = 32'd0;
        result.len    = frame.len;
        if (frame.len >= 4'd2) begin
            priority if (is_position) begin
                if (joint_ok) begin
                    result.status = ST_POS_OK;
                    result.pos    = frame.pos;
                end else begin
                    result.status = ST_JOINT_RANGE;
                end
            end else if (frame.fn == FN_FAILED) begin
                result.status = ST_FAILED;
            end else if (frame.fn == FN_TORQUE_BACK) begin
                result.status = ST_TORQUE_BACK;
            end else begin
                result.status = ST_OTHER;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/motor_reply_frame_decoder_unit.sv
// Top level of the motor reply frame decoder with input, result and config registers.
`default_nettype none

// Takes one received bus byte per request and emits one result request for
// each frame closed by the terminator byte 0x6B. Bytes of value zero are dropped
// while no frame is open. A byte passes through an input register, then the
// frame counter, byte store and classifier, then the result register, which
// holds the result request of a closing byte until the result side takes it.
// One byte is accepted in every cycle as long as the result side takes its
// requests. The config register highest_joint sets the largest joint
// address whose position reply is accepted; write it only while the block is idle.
module motor_reply_frame_decoder_unit
    import mrfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // joint_address, position_count, frame_length, zero pad
    output logic [2:0]       m_tuser    // frame_status
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] highest_joint_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       advance;
    frame_t     frame;
    result_t    result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            highest_joint_reg <= HIGHEST_JOINT_RST;
        end else if (cfg_wen) begin
            highest_joint_reg <= cfg_wdata;
        end
    end

    mrfd_frame_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .frame   (frame)
    );

    mrfd_classify u_classify (
        .frame         (frame),
        .highest_joint (highest_joint_reg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (frame.close) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame.close) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {4'd0, out_reg.len, out_reg.pos, out_reg.joint};

    // An accepted position reply is always exactly eight bytes long.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_POS_OK) |-> m_tdata[43:40] == POSITION_LEN)
        else $error("Accepted position reply with wrong length.");

    // The position field is zero unless the reply was accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_POS_OK) |-> m_tdata[39:8] == 32'd0)
        else $error("Nonzero position on a rejected frame.");

    // A closed frame never reports a length of zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[43:40] != 4'd0)
        else $error("Result with zero frame length.");

endmodule

`default_nettype wire

>>> bench/motor_reply_frame_decoder_unit_tb.sv
// Self-checking testbench for the motor reply frame decoder top level.
`timescale 1ns / 1ps

module motor_reply_frame_decoder_unit_tb;
    import mrfd_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 6;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 40;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        result_t    reply;
    } directed_row_t;

    localparam result_t NO_REPLY = '0;

    localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{8'h00, 1'b0, NO_REPLY},
        '{8'h6B, 1'b1, '{ST_OTHER, 8'h6B, 32'h0000_0000, 4'd1}},
        '{8'h05, 1'b0, NO_REPLY}, '{8'h30, 1'b0, NO_REPLY}, '{8'h00, 1'b0, NO_REPLY},
        '{8'h80, 1'b0, NO_REPLY}, '{8'h00, 1'b0, NO_REPLY}, '{8'h00, 1'b0, NO_REPLY},
        '{8'h00, 1'b0, NO_REPLY},
        '{8'h6B, 1'b1, '{ST_POS_OK, 8'h05, 32'h8000_0000, 4'd8}},
        '{8'h06, 1'b0, NO_REPLY}, '{8'h30, 1'b0, NO_REPLY}, '{8'h7F, 1'b0, NO_REPLY},
        '{8'h7F, 1'b0, NO_REPLY}, '{8'hFF, 1'b0, NO_REPLY}, '{8'hFF, 1'b0, NO_REPLY},
        '{8'hFF, 1'b0, NO_REPLY},
        '{8'h6B, 1'b1, '{ST_JOINT_RANGE, 8'h06, 32'h0000_0000, 4'd8}},
        '{8'h01, 1'b0, NO_REPLY}, '{8'h00, 1'b0, NO_REPLY},
        '{8'h6B, 1'b1, '{ST_FAILED, 8'h01, 32'h0000_0000, 4'd3}},
        '{8'hFF, 1'b0, NO_REPLY}, '{8'hF5, 1'b0, NO_REPLY},
        '{8'h6B, 1'b1, '{ST_TORQUE_BACK, 8'hFF, 32'h0000_0000, 4'd3}},
        '{8'h03, 1'b0, NO_REPLY}, '{8'h30, 1'b0, NO_REPLY}, '{8'h01, 1'b0, NO_REPLY},
        '{8'h02, 1'b0, NO_REPLY}, '{8'h03, 1'b0, NO_REPLY}, '{8'h04, 1'b0, NO_REPLY},
        '{8'h05, 1'b0, NO_REPLY}, '{8'h06, 1'b0, NO_REPLY}, '{8'h07, 1'b0, NO_REPLY},
        '{8'h08, 1'b0, NO_REPLY}, '{8'h09, 1'b0, NO_REPLY}, '{8'h0A, 1'b0, NO_REPLY},
        '{8'h0B, 1'b0, NO_REPLY}, '{8'h0C, 1'b0, NO_REPLY}, '{8'h0D, 1'b0, NO_REPLY},
        '{8'h6B, 1'b1, '{ST_OTHER, 8'h03, 32'h0000_0000, 4'd15}}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    logic [7:0]  joint_limit = HIGHEST_JOINT_RST;
    logic [3:0]  frame_len = 4'd0;
    logic [7:0]  frame_store [0:STORE_DEPTH-1];
    result_t     replies_due [$];

    int          mismatches = 0;
    int          bytes_sent = 0;
    int          s_idle_pct = 0;
    int          m_idle_pct = 0;
    int          idle_cycles = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    always #1 aclk = ~aclk;

    motor_reply_frame_decoder_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    task automatic decode_rx_byte(input logic [7:0] rx, output bit closed,
                                  output result_t reply);
        logic [3:0] len;
        closed = 1'b0;
        reply = NO_REPLY;
        if (rx == 8'h00 && frame_len == 4'd0) begin
            return;
        end
        if (frame_len < STORE_DEPTH) begin
            frame_store[frame_len] = rx;
        end
        if (frame_len < LEN_MAX) begin
            frame_len = frame_len + 4'd1;
        end
        if (rx != TERMINATOR_BYTE) begin
            return;
        end
        len = frame_len;
        frame_len = 4'd0;
        closed = 1'b1;
        reply.status = ST_OTHER;
        reply.joint = frame_store[0];
        reply.pos = 32'h0;
        reply.len = len;
        if (len >= 4'd2) begin
            if (frame_store[1] == FN_POSITION && len == POSITION_LEN) begin
                if (frame_store[0] >= 8'd1 && frame_store[0] <= joint_limit) begin
                    reply.status = ST_POS_OK;
                    reply.pos = {frame_store[3], frame_store[4], frame_store[5],
                                 frame_store[6]};
                end else begin
                    reply.status = ST_JOINT_RANGE;
                end
            end else if (frame_store[1] == FN_FAILED) begin
                reply.status = ST_FAILED;
            end else if (frame_store[1] == FN_TORQUE_BACK) begin
                reply.status = ST_TORQUE_BACK;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] rx, input logic use_typed,
                             input result_t typed_reply);
        bit      closed;
        result_t reply;
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= rx;
        @(negedge aclk);
        while (!s_tready) begin
            @(negedge aclk);
        end
        @(posedge aclk);
        bytes_sent++;
        decode_rx_byte(rx, closed, reply);
        if (closed) begin
            replies_due = {replies_due, (use_typed ? typed_reply : reply)};
        end
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_joint_limit(input logic [7:0] value);
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        joint_limit = value;
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == TERMINATOR_BYTE) begin
            b = b ^ 8'h01;
        end
        return b;
    endfunction

    function automatic logic [7:0] pos_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return body_byte();
        endcase
    endfunction

    task automatic send_random_frame();
        logic [7:0]  frame_q [$];
        logic [31:0] word;
        int          kind;
        int          n;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) frame_q = {frame_q, 8'h00};
        end
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            if ($urandom_range(0, 4) == 0 && joint_limit != 8'hFF) begin
                frame_q = {frame_q, 8'($urandom_range(joint_limit + 1, 255))};
            end else begin
                frame_q = {frame_q, 8'($urandom_range(1, joint_limit))};
            end
            frame_q = {frame_q, FN_POSITION};
            frame_q = {frame_q, body_byte()};
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: word = 32'h8000_0000;
                    1: word = 32'h7FFF_FFFF;
                    2: word = 32'h0000_0000;
                    default: word = 32'hFFFF_FFFF;
                endcase
            end else begin
                word = {pos_byte(), pos_byte(), pos_byte(), pos_byte()};
            end
            frame_q = {frame_q, word[31:24]};
            frame_q = {frame_q, word[23:16]};
            frame_q = {frame_q, word[15:8]};
            frame_q = {frame_q, word[7:0]};
            frame_q = {frame_q, TERMINATOR_BYTE};
        end else if (kind <= 8) begin
            frame_q = {frame_q, 8'($urandom_range(1, 255))};
            case (kind)
                4: frame_q = {frame_q, FN_FAILED};
                5: frame_q = {frame_q, FN_TORQUE_BACK};
                6: frame_q = {frame_q, FN_POSITION};
                default: frame_q = {frame_q, body_byte()};
            endcase
            case (kind)
                6: begin
                    n = $urandom_range(0, 9);
                    if (n >= 5) begin
                        n++;
                    end
                end
                7: n = $urandom_range(12, 20);
                default: n = $urandom_range(0, 5);
            endcase
            repeat (n) frame_q = {frame_q, body_byte()};
            frame_q = {frame_q, TERMINATOR_BYTE};
        end else begin
            repeat ($urandom_range(1, 6)) frame_q = {frame_q, 8'($urandom_range(0, 255))};
        end
        foreach (frame_q[i]) begin
            send_byte(frame_q[i], 1'b0, NO_REPLY);
        end
    endtask

    task automatic send_frames(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count) begin
            send_random_frame();
        end
    endtask

    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    always @(negedge aclk) begin : reply_monitor
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.joint = m_tdata[7:0];
            got.pos = m_tdata[39:8];
            got.len = m_tdata[43:40];
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected reply: status %0d joint %02h pos %08h len %0d",
                             got.status, got.joint, got.pos, got.len);
                end
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display({"reply mismatch: expected status %0d joint %02h ",
                                  "pos %08h len %0d, got status %0d joint %02h ",
                                  "pos %08h len %0d"},
                                 want.status, want.joint, want.pos, want.len,
                                 got.status, got.joint, got.pos, got.len);
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("** motor_reply_frame_decoder_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].reply);
        end
        drain_replies();

        write_joint_limit(8'd1);
        s_idle_pct = 14;
        m_idle_pct = 61;
        send_frames(150);
        drain_replies();

        write_joint_limit(8'd255);
        s_idle_pct = 61;
        m_idle_pct = 14;
        send_frames(150);
        drain_replies();

        write_joint_limit(8'($urandom_range(2, 254)));
        s_idle_pct = 0;
        m_idle_pct = 0;
        send_frames(60);
        hold_seq <= hold_seq + 1;
        send_frames(40);
        drain_replies();
        send_frames(60);
        drain_replies();

        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("** motor_reply_frame_decoder_unit: PASSED **");
        end else begin
            $display("** motor_reply_frame_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
